@@ sv/rav_pkg.sv @@
// rav_pkg: shared widths, constants and divider request/response types for the running average filter
// used by rav_div, running_average_filter and the tb testbench; depends on nothing

package rav_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int MAX_WINDOW = 32;
    localparam int SLOT_W     = $clog2(MAX_WINDOW);
    localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W      = SAMPLE_W + SLOT_W;
    localparam int DIV_STEPS  = SUM_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    localparam logic [CNT_W-1:0] WINDOW_RESET = CNT_W'(20);
    localparam logic [CNT_W-1:0] WINDOW_MAX   = CNT_W'(MAX_WINDOW);

    // register index of window_size
    localparam int REG_WINDOW = 0;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [SAMPLE_W-1:0] quotient;
    } t_div_rsp;

endpackage

@@ sv/running_average_filter.sv @@
// running_average_filter: moving average over the last window_size samples
// depends on rav_pkg, rav_ram (sample ring store) and rav_div (serial divider)
//
//  channel   | direction | handshake                  | payload
//  s_axis    | in        | s_axis_tvalid/tready       | tdata[15:0] sample
//  m_axis    | out       | m_axis_tvalid/tready       | tdata[15:0] average
//  apb       | in        | psel/penable/pwrite/pready | reg 0 at 0x0: window_size[5:0]
//
// each sample passes through accept, store read and sum update, 21 divider
// steps in rav_div (one quotient bit per cycle), then the load into the output register
// a new sample is taken while the previous average waits in the output register
// the output register holds its average until m_axis_tready; the divider holds
// its quotient while the output is stalled
// synchronous active-low reset; no clearing pass, the fill count masks stale entries

module running_average_filter
    import rav_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [SAMPLE_W-1:0] s_axis_tdata,   // [15:0] sample
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [SAMPLE_W-1:0] m_axis_tdata,   // [15:0] average
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_UPD  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;

    logic [1:0]          r_state;
    logic [1:0]          n_state;
    logic [CNT_W-1:0]    r_window;
    logic [SLOT_W-1:0]   r_slot;
    logic [SLOT_W-1:0]   n_slot;
    logic [CNT_W-1:0]    r_fill;
    logic [CNT_W-1:0]    n_fill;
    logic [SUM_W-1:0]    r_sum;
    logic [SUM_W-1:0]    n_sum;
    logic [SAMPLE_W-1:0] r_sample;
    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_out_data;

    logic                w_in_req;
    logic                w_cfg_wr;
    logic                w_load;
    logic [CNT_W-1:0]    w_size;
    logic [SLOT_W-1:0]   w_slot;
    logic [CNT_W-1:0]    w_slot_inc;
    logic [SAMPLE_W-1:0] w_old;
    logic [SAMPLE_W-1:0] w_rdata;
    t_div_req            w_div_req;
    t_div_rsp            w_div_rsp;

    assign w_in_req = s_axis_tvalid && s_axis_tready;
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign w_load   = (r_state == ST_DIV) && w_div_rsp.done && (!r_out_valid || m_axis_tready);

    // zero acts as one, above the store depth saturates
    always_comb begin
        if (r_window == '0) begin
            w_size = CNT_W'(1);
        end else if (r_window > WINDOW_MAX) begin
            w_size = WINDOW_MAX;
        end else begin
            w_size = r_window;
        end
    end

    always_comb begin
        w_slot = ({1'b0, r_slot} >= w_size) ? '0 : r_slot;
        w_slot_inc = {1'b0, w_slot} + 1'b1;
        n_slot = (w_slot_inc >= w_size) ? '0 : w_slot_inc[SLOT_W-1:0];
        n_fill = (r_fill < w_size) ? r_fill + 1'b1 : w_size;
        // entry is live only once the ring is full
        w_old  = (r_fill >= w_size) ? w_rdata : '0;
        n_sum  = r_sum - SUM_W'(w_old) + SUM_W'(r_sample);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_req) begin
                    n_state = ST_UPD;
                end
            end
            ST_UPD: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_window    <= WINDOW_RESET;
            r_slot      <= '0;
            r_fill      <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cfg_wr) begin
                r_window <= pwdata[CNT_W-1:0];
                r_slot   <= '0;
                r_fill   <= '0;
                r_sum    <= '0;
            end else if (r_state == ST_UPD) begin
                r_slot <= n_slot;
                r_fill <= n_fill;
                r_sum  <= n_sum;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_req) begin
            r_sample <= s_axis_tdata;
        end
        if (w_load) begin
            r_out_data <= w_div_rsp.quotient;
        end
    end

    rav_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_WINDOW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (r_state == ST_UPD),
        .i_waddr (w_slot),
        .i_wdata (r_sample),
        .i_re    (w_in_req),
        .i_raddr (w_slot),
        .o_rdata (w_rdata)
    );

    assign w_div_req.start    = (r_state == ST_UPD);
    assign w_div_req.dividend = n_sum;
    assign w_div_req.divisor  = n_fill;

    rav_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign pready        = 1'b1;
    assign prdata        = (paddr[2] == 1'b0) ? {{(32 - CNT_W){1'b0}}, r_window} : '0;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= w_size)
        else $error("fill count above window size");

    a_slot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_slot} < w_size)
        else $error("write slot outside window");

    a_req_to_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_req && !w_cfg_wr |=> r_state == ST_UPD)
        else $error("accepted sample did not start an update");

    a_load_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_div_rsp.done))
        else $error("output loaded before divider finished");

endmodule

@@ sv/rav_ram.sv @@
// rav_ram: generic single-port-write, single-port-read ram with registered read data
// no dependencies

module rav_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/rav_div.sv @@
// rav_div: bit-serial restoring divider, one quotient bit per cycle
// depends on rav_pkg for widths and the request/response structs

module rav_div
    import rav_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [SUM_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_dsr;

    logic [CNT_W-1:0]  w_partial;
    logic [CNT_W:0]    w_trial;
    logic              w_fits;

    // remainder stays below the divisor, so its top bit is free for the shift
    assign w_partial = {r_rem[CNT_W-2:0], r_quo[SUM_W-1]};
    assign w_trial   = {1'b0, w_partial} - {1'b0, r_dsr};
    assign w_fits    = ~w_trial[CNT_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_step <= STEP_W'(DIV_STEPS - 1);
        end else if (r_busy) begin
            r_step <= r_step - 1'b1;
            if (r_step == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dsr <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[SUM_W-2:0], w_fits};
            r_rem <= w_fits ? w_trial[CNT_W-1:0] : w_partial;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo[SAMPLE_W-1:0];

endmodule

@@ dv/tb.sv @@
// tb: self-checking testbench for running_average_filter, directed and random sample streams
// predicts each average from its own copy of the ring store, sum, slot and fill count
// depends on rav_pkg and the running_average_filter rtl

module tb;
    import rav_pkg::*;

    localparam int          IDLE_LIMIT  = 1000;
    localparam int          DRAIN_WAIT  = 40;
    localparam int          RANDOM_ITEMS = 1100;
    localparam logic [2:0]  WINDOW_ADDR = 3'(REG_WINDOW * 4);

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [SAMPLE_W-1:0] s_axis_tdata = '0;   // [15:0] sample
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [SAMPLE_W-1:0] m_axis_tdata;        // [15:0] average
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [2:0]          paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    // predictor state
    logic [5:0]          win_reg;
    logic [SAMPLE_W-1:0] ring [MAX_WINDOW];
    int unsigned         ring_slot;
    int unsigned         ring_fill;
    int unsigned         ring_sum;

    logic [SAMPLE_W-1:0] expected_avg [$];
    int                  error_count = 0;
    int                  idle_cycles = 0;
    bit                  no_idle = 1'b0;

    running_average_filter u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #6 i_clk = ~i_clk;

    function automatic void clear_ring();
        for (int i = 0; i < MAX_WINDOW; i++) begin
            ring[i] = '0;
        end
        ring_slot = 0;
        ring_fill = 0;
        ring_sum  = 0;
    endfunction

    function automatic logic [SAMPLE_W-1:0] fold_in_sample(input logic [SAMPLE_W-1:0] s);
        int unsigned size;
        int unsigned slot;
        size = (win_reg == 0) ? 1 : ((win_reg > MAX_WINDOW) ? MAX_WINDOW : win_reg);
        slot = ring_slot;
        if (slot >= size) begin
            slot = 0;
        end
        ring_sum   = ring_sum - ring[slot] + s;
        ring[slot] = s;
        slot++;
        if (slot >= size) begin
            slot = 0;
        end
        ring_slot = slot;
        if (ring_fill < size) begin
            ring_fill++;
        end
        if (ring_fill > size) begin
            ring_fill = size;
        end
        return SAMPLE_W'(ring_sum / ring_fill);
    endfunction

    function automatic int unsigned draw_gap();
        return no_idle ? 0 : $urandom_range(0, 3);
    endfunction

    task automatic send_sample(input logic [SAMPLE_W-1:0] value);
        int unsigned gap;
        gap = draw_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_avg.push_back(fold_in_sample(value));
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_avg.size() != 0) @(posedge i_clk);
    endtask

    task automatic read_window();
        logic [31:0] got;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= WINDOW_ADDR;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        if (got[5:0] !== win_reg) begin
            $error("window_size: expected %0d, actual %0d", win_reg, got[5:0]);
            error_count++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_window(input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= WINDOW_ADDR;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        win_reg = value[5:0];
        clear_ring();
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        read_window();
    endtask

    task automatic test_reset_default();
        read_window();
        send_sample(16'hFFFF);
        send_sample(16'h0000);
        send_sample(16'hAAAA);
        send_sample(16'h5555);
        drain_results();
    endtask

    task automatic test_window_limits();
        write_window(32'd1);
        send_sample(16'hFFFF);
        send_sample(16'h0001);
        send_sample(16'h0000);
        drain_results();
        // zero acts as a single-sample window
        write_window(32'd0);
        send_sample(16'h0007);
        send_sample(16'hFFFF);
        drain_results();
        // oversize window saturates
        write_window(32'd63);
        repeat (4) send_sample(16'hFFFF);
        drain_results();
        write_window({26'h3FFFFFF, 6'd32});
        repeat (4) send_sample(16'hFFFF);
        drain_results();
        write_window(32'd2);
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        send_sample(16'hFFFF);
        drain_results();
    endtask

    task automatic test_random_windows();
        int          sent;
        int unsigned len;
        logic [5:0]  win;
        logic [15:0] s;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0: win = 6'd1;
                1: win = 6'd32;
                2: win = 6'd0;
                3: win = 6'($urandom_range(33, 63));
                default: win = 6'($urandom_range(1, 32));
            endcase
            no_idle = ($urandom_range(0, 3) == 0);
            write_window({26'($urandom() >> 6), win});
            len = $urandom_range(8, 90);
            repeat (len) begin
                case ($urandom_range(0, 7))
                    0: s = 16'h0000;
                    1: s = 16'hFFFF;
                    2: s = 16'($urandom_range(0, 15));
                    3: s = 16'hFFFF - 16'($urandom_range(0, 15));
                    default: s = 16'($urandom());
                endcase
                send_sample(s);
                sent++;
            end
            drain_results();
        end
        no_idle = 1'b0;
    endtask

    // result side: random stall before each result, none while no_idle is set
    initial begin
        int unsigned gap;
        forever begin
            @(negedge i_clk);
            gap = draw_gap();
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(i_rst_n && m_axis_tvalid && m_axis_tready));
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_avg.size() == 0) begin
                $error("average: expected none, actual %0d", m_axis_tdata);
                error_count++;
            end else begin
                if (m_axis_tdata !== expected_avg[0]) begin
                    $error("average: expected %0d, actual %0d", expected_avg[0], m_axis_tdata);
                    error_count++;
                end
                void'(expected_avg.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (psel && penable && pready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        win_reg = WINDOW_RESET[5:0];
        clear_ring();
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_default();
        test_window_limits();
        test_random_windows();
        drain_results();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ running_average_filter.f @@
sv/rav_pkg.sv
sv/rav_ram.sv
sv/rav_div.sv
sv/running_average_filter.sv
dv/tb.sv
